/* rtl/radix32_number_parser_top_defines.svh */
// assertion macros for the radix-32 number parser
`ifndef RADIX32_NUMBER_PARSER_TOP_DEFINES_SVH
`define RADIX32_NUMBER_PARSER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define R32P_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define R32P_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/r32p_pkg.sv */
package r32p_pkg;

	// character codes of interest
	localparam logic [15:0] CH_TAB   = 16'h0009;
	localparam logic [15:0] CH_CR    = 16'h000D;
	localparam logic [15:0] CH_SPACE = 16'h0020;
	localparam logic [15:0] CH_PLUS  = 16'h002B;
	localparam logic [15:0] CH_MINUS = 16'h002D;
	localparam logic [15:0] CH_ZERO  = 16'h0030;
	localparam logic [15:0] CH_NINE  = 16'h0039;
	localparam logic [15:0] CH_UP_A  = 16'h0041;
	localparam logic [15:0] CH_UP_V  = 16'h0056;
	localparam logic [15:0] CH_LO_A  = 16'h0061;
	localparam logic [15:0] CH_LO_V  = 16'h0076;
	localparam logic [4:0]  DIGIT_TEN = 5'd10;

	localparam int VALUE_W = 64;
	localparam int DIGIT_W = 5;

	// class of one character word
	typedef struct packed {
		logic                is_space;
		logic                is_plus;
		logic                is_minus;
		logic                is_digit;
		logic [DIGIT_W-1:0]  digit;
	} char_class_t;

endpackage

/* rtl/r32p_classify.sv */
module r32p_classify (
	input  logic [15:0]              char_code,
	output r32p_pkg::char_class_t    cls
);

	logic [15:0] off_num;
	logic [15:0] off_up;
	logic [15:0] off_lo;
	logic        in_num;
	logic        in_up;
	logic        in_lo;

	// range checks for digits in both cases
	assign in_num  = (char_code >= r32p_pkg::CH_ZERO) && (char_code <= r32p_pkg::CH_NINE);
	assign in_up   = (char_code >= r32p_pkg::CH_UP_A) && (char_code <= r32p_pkg::CH_UP_V);
	assign in_lo   = (char_code >= r32p_pkg::CH_LO_A) && (char_code <= r32p_pkg::CH_LO_V);
	assign off_num = char_code - r32p_pkg::CH_ZERO;
	assign off_up  = char_code - r32p_pkg::CH_UP_A;
	assign off_lo  = char_code - r32p_pkg::CH_LO_A;

	// class flags and digit value
	always_comb begin
		cls.is_space = (char_code == r32p_pkg::CH_SPACE) ||
			((char_code >= r32p_pkg::CH_TAB) && (char_code <= r32p_pkg::CH_CR));
		cls.is_plus  = (char_code == r32p_pkg::CH_PLUS);
		cls.is_minus = (char_code == r32p_pkg::CH_MINUS);
		cls.is_digit = in_num || in_up || in_lo;
		priority if (in_num) begin
			cls.digit = off_num[r32p_pkg::DIGIT_W-1:0];
		end else if (in_up) begin
			cls.digit = off_up[r32p_pkg::DIGIT_W-1:0] + r32p_pkg::DIGIT_TEN;
		end else begin
			cls.digit = off_lo[r32p_pkg::DIGIT_W-1:0] + r32p_pkg::DIGIT_TEN;
		end
	end

endmodule

/* rtl/r32p_scan.sv */
module r32p_scan (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             advance,
	input  r32p_pkg::char_class_t            cls,
	output logic                             term,
	output logic [r32p_pkg::VALUE_W-1:0]     value,
	output logic                             overflowed,
	output logic                             digits_found
);

	typedef enum logic [1:0] {
		PH_LEAD = 2'd0,
		PH_BODY = 2'd1
	} phase_t;

	localparam int TOP_W = r32p_pkg::DIGIT_W;

	phase_t                         phase_q;
	logic [r32p_pkg::VALUE_W-1:0]   acc_q;
	logic                           minus_q;
	logic                           ovf_q;
	logic                           dig_q;
	logic                           lead;
	logic                           skip;
	logic                           sign;
	logic [r32p_pkg::VALUE_W-1:0]   sel;

	// word decode against the current phase
	assign lead = (phase_q == PH_LEAD);
	assign skip = lead && cls.is_space;
	assign sign = lead && (cls.is_plus || cls.is_minus);
	assign term = !skip && !sign && !cls.is_digit;

	// result of the finished scan
	always_comb begin
		if (!dig_q) begin
			sel = '0;
		end else if (ovf_q) begin
			sel = '1;
		end else begin
			sel = acc_q;
		end
		value        = minus_q ? ('0 - sel) : sel;
		overflowed   = dig_q && ovf_q;
		digits_found = dig_q;
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			acc_q   <= '0;
			minus_q <= 1'b0;
			ovf_q   <= 1'b0;
			dig_q   <= 1'b0;
		end else if (advance) begin
			priority if (skip) begin
				phase_q <= PH_LEAD;
			end else if (sign) begin
				phase_q <= PH_BODY;
				minus_q <= cls.is_minus;
			end else if (cls.is_digit) begin
				phase_q <= PH_BODY;
				dig_q   <= 1'b1;
				if (acc_q[r32p_pkg::VALUE_W-1 -: TOP_W] != '0) begin
					ovf_q <= 1'b1;
				end else begin
					acc_q <= {acc_q[r32p_pkg::VALUE_W-TOP_W-1:0], cls.digit};
				end
			end else begin
				phase_q <= PH_LEAD;
				acc_q   <= '0;
				minus_q <= 1'b0;
				ovf_q   <= 1'b0;
				dig_q   <= 1'b0;
			end
		end
	end

endmodule

/* rtl/radix32_number_parser_top.sv */
// radix-32 number parser: one character word per cycle, unless a terminating word meets a blocked result
// a terminating word passes from the input register through the scan logic
// into the result register
// throughput: one word per cycle while no terminating word waits on a blocked result
// reset: arst_n clears the scan state and all valid flags; no result pending
`include "radix32_number_parser_top_defines.svh"

module radix32_number_parser_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [15:0]                      char_code,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [r32p_pkg::VALUE_W-1:0]     value,
	output logic                             overflowed,
	output logic                             digits_found
);

	logic                           valid_s1;
	logic [15:0]                    char_s1;
	r32p_pkg::char_class_t          cls;
	logic                           term;
	logic [r32p_pkg::VALUE_W-1:0]   res_value;
	logic                           res_ovf;
	logic                           res_dig;
	logic                           out_free;
	logic                           go_s1;
	logic                           out_valid_q;
	logic [r32p_pkg::VALUE_W-1:0]   value_q;
	logic                           ovf_q;
	logic                           dig_q;

	// stage one moves on unless a terminating word meets a blocked result
	assign out_free = !out_valid_q || out_ready;
	assign go_s1    = valid_s1 && (!term || out_free);
	assign in_ready = !valid_s1 || go_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_code;
		end
	end

	r32p_classify u_classify (
		.char_code (char_s1),
		.cls       (cls)
	);

	r32p_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (go_s1),
		.cls          (cls),
		.term         (term),
		.value        (res_value),
		.overflowed   (res_ovf),
		.digits_found (res_dig)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= go_s1 && term;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && term) begin
			value_q <= res_value;
			ovf_q   <= res_ovf;
			dig_q   <= res_dig;
		end
	end

	assign out_valid    = out_valid_q;
	assign value        = value_q;
	assign overflowed   = ovf_q;
	assign digits_found = dig_q;

	// checks
	`R32P_ASSERT_IMP(a_stall_held, clk, arst_n, !in_ready,
		valid_s1 && term && !out_free, "input stalled without a blocked result")
	`R32P_ASSERT_IMP(a_ovf_needs_dig, clk, arst_n, out_valid && overflowed,
		digits_found && ((value == '1) || (value == 64'd1)), "overflow result malformed")
	`R32P_ASSERT_IMP(a_no_dig_zero, clk, arst_n, out_valid && !digits_found,
		(value == '0) && !overflowed, "empty scan gave non-zero result")
	`R32P_ASSERT_NXT(a_result_load, clk, arst_n, go_s1 && term, out_valid,
		"terminating word lost its result")

endmodule
